// File: hdl/aging_hash_table_cache_defines.svh
// Assertion macros for the aging hash table cache
`ifndef AGING_HASH_TABLE_CACHE_DEFINES_SVH
`define AGING_HASH_TABLE_CACHE_DEFINES_SVH
// a implies b on the next edge
`define AHT_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("label");
// a implies b on the same edge
`define AHT_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("label");
`endif

// File: hdl/aht_pkg.sv
// ----------------------------------------------------------------------------
// aht_pkg
// Shared types and constants of the aging hash table cache.
// ----------------------------------------------------------------------------
package aht_pkg;
  localparam int BUCKETS_DEF = 64;
  localparam int WAYS_DEF    = 4;
  localparam logic [15:0] AGE_RESET    = 16'd600;
  localparam logic [7:0]  PERIOD_RESET = 8'd60;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_LOAD   = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [0:0] CFG_AGE    = 1'b0;
  localparam logic [0:0] CFG_PERIOD = 1'b1;

  // compare unit result, compare unit to sequencer
  typedef struct packed {
    logic hit;
    logic is_free;
    logic aged;
  } cmp_t;
endpackage

// File: hdl/aht_cmp.sv
// ----------------------------------------------------------------------------
// aht_cmp
// Shared compare unit: key match, free slot and idle age for one slot.
// ----------------------------------------------------------------------------
module aht_cmp (
  input  logic            vld,
  input  logic [63:0]     slot_k,
  input  logic [31:0]     slot_t,
  input  logic [63:0]     key,
  input  logic [31:0]     now,
  input  logic [15:0]     max_age,
  output aht_pkg::cmp_t   res
);
  logic [31:0] age;
  assign age         = now - slot_t;
  assign res.hit     = vld && (slot_k == key);
  assign res.is_free = !vld;
  assign res.aged    = vld && (age >= {16'd0, max_age});
endmodule

// File: hdl/aging_hash_table_cache.sv
// ----------------------------------------------------------------------------
// aging_hash_table_cache
// Bucketed key store with last-used aging and periodic pruning sweeps.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries req_type, item_key and
// entry_payload; one result per item on out_valid/out_ready.
// Lookup and load walk the bucket's ways one slot a cycle through a
// single compare unit, then update the slot where needed and register
// the result. A tick without sweep goes straight to the result; a
// sweep tick walks every slot.
// The slot memory has one read port and one write port; the walk reads one slot per cycle.
// Reset clears all valid bits (flip-flops), time and phase counters and
// restores the register defaults. No clearing pass is needed.
// The result waits in an output register; intake resumes once it has
// been taken, so a stalled receiver holds the block.
// Configuration writes (cfg_valid/cfg_ready) are always accepted.
// ----------------------------------------------------------------------------
`include "aging_hash_table_cache_defines.svh"
module aging_hash_table_cache #(
  parameter int BUCKETS = aht_pkg::BUCKETS_DEF,
  parameter int WAYS    = aht_pkg::WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [63:0] item_key,
  input  logic [63:0] entry_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [63:0] found_payload,
  output logic [1:0]  status,
  output logic [8:0]  removed_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_WALK  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  logic [15:0] max_idle_age;
  logic [7:0]  sweep_period, sweep_phase;
  logic [31:0] now_seconds;
  logic [SLOTS-1:0] slot_valid;
  logic [63:0] slot_key [SLOTS];
  logic [63:0] slot_payload [SLOTS];
  logic [31:0] slot_last_used [SLOTS];

  logic [1:0]  req;
  logic [63:0] key, pay;
  logic [BW-1:0] bucket;
  logic [SW-1:0] idx, rd_idx;
  logic [WW:0]   way;
  logic [CW-1:0] cnt;
  logic [63:0] rd_key, rd_pay;
  logic [31:0] rd_time;
  logic        rd_vld, have_free, have_hit;
  logic [SW-1:0] free_idx;
  aht_pkg::cmp_t cmp;
  logic [7:0] phase_inc;

  function automatic logic [SW-1:0] slot_of(input logic [BW-1:0] b, input logic [WW:0] w);
    logic [31:0] s;
    s = 32'(b) * 32'(WAYS) + 32'(w);
    return s[SW-1:0];
  endfunction

  aht_cmp u_cmp (
    .vld(rd_vld), .slot_k(rd_key), .slot_t(rd_time), .key(key),
    .now(now_seconds), .max_age(max_idle_age), .res(cmp)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == S_OUT);
  assign phase_inc = sweep_phase + 8'd1;

  // memory read, registered
  always_ff @(posedge clk) begin
    rd_key  <= slot_key[idx];
    rd_pay  <= slot_payload[idx];
    rd_time <= slot_last_used[idx];
    rd_vld  <= slot_valid[idx];
    rd_idx  <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_idle_age <= aht_pkg::AGE_RESET;
      sweep_period <= aht_pkg::PERIOD_RESET;
      sweep_phase <= 8'd0;
      now_seconds <= 32'd0;
      slot_valid <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          aht_pkg::CFG_AGE:    max_idle_age <= cfg_data;
          aht_pkg::CFG_PERIOD: sweep_period <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          req <= req_type;
          key <= item_key;
          pay <= entry_payload;
          found <= 1'b0;
          found_payload <= '0;
          status <= aht_pkg::ST_OK;
          removed_count <= '0;
          bucket <= BW'(item_key % 64'(BUCKETS));
          way <= '0;
          have_free <= 1'b0;
          have_hit <= 1'b0;
          cnt <= '0;
          if (req_type == aht_pkg::REQ_TICK) begin
            now_seconds <= now_seconds + 32'd1;
            if (phase_inc >= sweep_period) begin
              sweep_phase <= 8'd0;
              idx <= '0;
              state <= S_READ;
            end else begin
              sweep_phase <= phase_inc;
              state <= S_OUT;
            end
          end else if (req_type == aht_pkg::REQ_LOOKUP || req_type == aht_pkg::REQ_LOAD) begin
            idx <= slot_of(BW'(item_key % 64'(BUCKETS)), '0);
            state <= S_READ;
          end else begin
            state <= S_OUT;
          end
        end
        S_READ: begin
          if (req == aht_pkg::REQ_TICK) begin
            idx <= idx + SW'(1);
            state <= S_SWEEP;
          end else begin
            way <= way + (WW+1)'(1);
            idx <= slot_of(bucket, way + (WW+1)'(1));
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (cmp.hit) begin
            slot_last_used[rd_idx] <= now_seconds;
            found <= 1'b1;
            found_payload <= rd_pay;
            state <= S_OUT;
          end else begin
            if (cmp.is_free && !have_free) begin
              have_free <= 1'b1;
              free_idx <= rd_idx;
            end
            if (way < (WW+1)'(WAYS)) begin
              way <= way + (WW+1)'(1);
              idx <= slot_of(bucket, way + (WW+1)'(1));
            end else begin
              state <= S_OUT;
              if (req == aht_pkg::REQ_LOOKUP) status <= aht_pkg::ST_MISS;
              else if (have_free || cmp.is_free) begin
                slot_valid[have_free ? free_idx : rd_idx] <= 1'b1;
                slot_key[have_free ? free_idx : rd_idx] <= key;
                slot_payload[have_free ? free_idx : rd_idx] <= pay;
                slot_last_used[have_free ? free_idx : rd_idx] <= now_seconds;
              end else status <= aht_pkg::ST_FULL;
            end
          end
        end
        S_SWEEP: begin
          if (cmp.aged) begin
            slot_valid[rd_idx] <= 1'b0;
            cnt <= cnt + CW'(1);
          end
          idx <= idx + SW'(1);
          if (32'(rd_idx) == 32'(SLOTS - 1)) begin
            removed_count <= 9'(cnt + CW'(cmp.aged));
            state <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `AHT_ASSERT_NOW(a_one_side, in_ready, !out_valid)
  `AHT_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(status))
  `AHT_ASSERT_NOW(a_found_ok, out_valid && found, status == aht_pkg::ST_OK)
  `AHT_ASSERT_NOW(a_rm_tick, out_valid && removed_count != 9'd0, req == aht_pkg::REQ_TICK)
endmodule
